FILE: src/elc_pkg.sv
`timescale 1ns / 1ps

package elc_pkg;

   localparam int ELC_MEAS_WIDTH = 18;
   localparam int ELC_FRAC_BITS = 12;
   localparam int ELC_RD_WIDTH = 7;
   localparam int ELC_CSR_INDEX_WIDTH = 3;

   // Percent scale of the LED dynamic resistance coefficient.
   localparam int ELC_RD_SCALE = 100;

   localparam int ELC_SHORT_LOW_CURRENT = 199000;
   localparam int ELC_SHORT_HIGH_CURRENT = 180000;

   typedef logic [2:0] elc_mode_type;

   localparam elc_mode_type MODE_CC = 3'd0;
   localparam elc_mode_type MODE_CV = 3'd1;
   localparam elc_mode_type MODE_CR = 3'd2;
   localparam elc_mode_type MODE_CP = 3'd3;
   localparam elc_mode_type MODE_DYNAMIC = 3'd4;
   localparam elc_mode_type MODE_LED = 3'd5;
   localparam elc_mode_type MODE_SHORT = 3'd6;

   typedef logic [ELC_CSR_INDEX_WIDTH-1:0] elc_csr_index_type;

   localparam elc_csr_index_type CSR_VON_LEVEL = 3'd0;
   localparam elc_csr_index_type CSR_VOFF_LEVEL = 3'd1;
   localparam elc_csr_index_type CSR_LED_FORWARD_VOLTAGE = 3'd2;
   localparam elc_csr_index_type CSR_LED_FORWARD_CURRENT = 3'd3;
   localparam elc_csr_index_type CSR_LED_RD_PERCENT = 3'd4;
   localparam elc_csr_index_type CSR_I_LOW_RANGE_MAX = 3'd5;
   localparam elc_csr_index_type CSR_V_LOW_RANGE_MAX = 3'd6;

   // Status that the LED set-point unit hands back to the control core.
   typedef struct packed {
      logic done;
      logic conducts;
   } elc_led_status_type;

endpackage

FILE: src/elc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module elc_div #(
   parameter int DIVIDEND_WIDTH = 30,
   parameter int DIVISOR_WIDTH = 18
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic                      done,
   output logic [DIVIDEND_WIDTH-1:0] quotient
);

   localparam int CW = $clog2(DIVIDEND_WIDTH + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_WIDTH-1:0] quot_ff, quot_in;
   logic [DIVISOR_WIDTH-1:0]  div_ff, div_in;
   logic [DIVISOR_WIDTH:0]    trial;
   logic [DIVISOR_WIDTH:0]    diff;
   logic                      fits;

   assign trial = {rem_ff, quot_ff[DIVIDEND_WIDTH-1]};
   assign diff = trial - {1'b0, div_ff};
   assign fits = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      div_in = div_ff;
      if (start) begin
         busy_in = 1'b1;
         count_in = CW'(DIVIDEND_WIDTH);
         rem_in = '0;
         quot_in = dividend;
         div_in = divisor;
      end else if (busy_ff) begin
         // The partial remainder always stays below the divisor.
         rem_in = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         quot_in = {quot_ff[DIVIDEND_WIDTH-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: src/elc_mul.sv
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle, least significant first.
module elc_mul #(
   parameter int A_WIDTH = 30,
   parameter int B_WIDTH = 18
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [A_WIDTH-1:0]         a,
   input  logic [B_WIDTH-1:0]         b,
   output logic                       done,
   output logic [A_WIDTH+B_WIDTH-1:0] product
);

   localparam int PW = A_WIDTH + B_WIDTH;
   localparam int CW = $clog2(B_WIDTH + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [A_WIDTH-1:0] a_ff, a_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [A_WIDTH:0]   sum;

   // The low part of the product register still holds the unused multiplier bits.
   assign sum = {1'b0, prod_ff[PW-1:B_WIDTH]} + (prod_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      a_in = a_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         count_in = CW'(B_WIDTH);
         a_in = a;
         prod_in = {{A_WIDTH{1'b0}}, b};
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[B_WIDTH-1:1]};
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      a_ff <= a_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign product = prod_ff;

endmodule

FILE: src/elc_led_calc.sv
`timescale 1ns / 1ps

// LED-mode set-point: turn-on voltage, slope and linear current law, worked
// out on one serial multiplier and one serial divider.
module elc_led_calc
   import elc_pkg::*;
#(
   parameter int MEAS_WIDTH = ELC_MEAS_WIDTH,
   parameter int FRAC_BITS = ELC_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [MEAS_WIDTH-1:0]   vo,
   input  logic [MEAS_WIDTH-1:0]   io,
   input  logic [ELC_RD_WIDTH-1:0] rd,
   input  logic [MEAS_WIDTH-1:0]   coarse,
   output elc_led_status_type      status,
   output logic [MEAS_WIDTH-1:0]   setpoint
);

   localparam int DW = MEAS_WIDTH + FRAC_BITS;
   localparam int PW = DW + MEAS_WIDTH;

   localparam logic [2:0] C_IDLE = 3'd0;
   localparam logic [2:0] C_DROP_MUL = 3'd1;
   localparam logic [2:0] C_DROP_DIV = 3'd2;
   localparam logic [2:0] C_SLOPE_DIV = 3'd3;
   localparam logic [2:0] C_LINE_MUL = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic                    done_ff, done_in;
   logic                    conducts_ff, conducts_in;
   logic [MEAS_WIDTH-1:0]   setpoint_ff, setpoint_in;
   logic [MEAS_WIDTH-1:0]   vo_ff, io_ff, coarse_ff;

   logic                    mul_start, mul_done;
   logic [DW-1:0]           mul_a;
   logic [MEAS_WIDTH-1:0]   mul_b;
   logic [PW-1:0]           mul_product;
   logic                    div_start, div_done;
   logic [DW-1:0]           div_dividend, div_quotient;
   logic [MEAS_WIDTH-1:0]   div_divisor;

   logic [DW-1:0]           io_q;
   logic [MEAS_WIDTH-1:0]   on_v, den, gap;
   logic                    above;
   logic [PW:0]             up_sum, up_shift;
   logic [MEAS_WIDTH-1:0]   up_sp, down_sp;
   logic [PW-1:0]           io_q_wide, down_diff;

   assign io_q = {io_ff, {FRAC_BITS{1'b0}}};

   // The quotient of the drop division is Vo * Rd / 100; above Vo it floors on_v at zero.
   assign on_v = (div_quotient > DW'(vo_ff)) ? '0 : vo_ff - div_quotient[MEAS_WIDTH-1:0];
   assign den = vo_ff - on_v;

   assign above = coarse_ff >= vo_ff;
   assign gap = above ? coarse_ff - vo_ff : vo_ff - coarse_ff;

   assign up_sum = {1'b0, mul_product} + (PW + 1)'(io_q);
   assign up_shift = up_sum >> FRAC_BITS;
   assign up_sp = (|up_shift[PW:MEAS_WIDTH]) ? '1 : up_shift[MEAS_WIDTH-1:0];

   assign io_q_wide = PW'(io_q);
   assign down_diff = io_q_wide - mul_product;
   assign down_sp = (mul_product > io_q_wide) ? '0 :
                    down_diff[FRAC_BITS+MEAS_WIDTH-1:FRAC_BITS];

   assign mul_a = (state_ff == C_IDLE) ? DW'(vo) : div_quotient;
   assign mul_b = (state_ff == C_IDLE) ? MEAS_WIDTH'(rd) : gap;

   assign div_dividend = (state_ff == C_DROP_MUL) ? mul_product[DW-1:0] : io_q;
   assign div_divisor = (state_ff == C_DROP_MUL) ? MEAS_WIDTH'(ELC_RD_SCALE) : den;

   elc_mul #(
      .A_WIDTH(DW),
      .B_WIDTH(MEAS_WIDTH)
   ) u_mul (
      .clock(clock),
      .reset(reset),
      .start(mul_start),
      .a(mul_a),
      .b(mul_b),
      .done(mul_done),
      .product(mul_product)
   );

   elc_div #(
      .DIVIDEND_WIDTH(DW),
      .DIVISOR_WIDTH(MEAS_WIDTH)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_dividend),
      .divisor(div_divisor),
      .done(div_done),
      .quotient(div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      done_in = 1'b0;
      conducts_in = conducts_ff;
      setpoint_in = setpoint_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               mul_start = 1'b1;
               state_in = C_DROP_MUL;
            end
         end
         C_DROP_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in = C_DROP_DIV;
            end
         end
         C_DROP_DIV: begin
            if (div_done) begin
               conducts_in = coarse_ff >= on_v;
               if (coarse_ff < on_v) begin
                  setpoint_in = '0;
                  done_in = 1'b1;
                  state_in = C_IDLE;
               end else if (den == '0) begin
                  // A flat characteristic gives the operating current itself.
                  setpoint_in = io_ff;
                  done_in = 1'b1;
                  state_in = C_IDLE;
               end else begin
                  div_start = 1'b1;
                  state_in = C_SLOPE_DIV;
               end
            end
         end
         C_SLOPE_DIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               state_in = C_LINE_MUL;
            end
         end
         C_LINE_MUL: begin
            if (mul_done) begin
               setpoint_in = above ? up_sp : down_sp;
               done_in = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      conducts_ff <= conducts_in;
      setpoint_ff <= setpoint_in;
      if (start && state_ff == C_IDLE) begin
         vo_ff <= vo;
         io_ff <= io;
         coarse_ff <= coarse;
      end
   end

   assign status.done = done_ff;
   assign status.conducts = conducts_ff;
   assign setpoint = setpoint_ff;

endmodule

FILE: src/electronic_load_enable_control_core.sv
`timescale 1ns / 1ps

// Load enable and range control, evaluated once per control tick.
// One request transfer on req_* carries a tick's mode, on/off command and
// measurements; one response transfer on rsp_* carries the load enable, loop
// select, range bits, pulses and set-points for that tick. Thresholds and LED
// parameters must be written through csr_* while no tick is in progress; the
// block itself does not enforce this. A tick in any mode but LED with the load
// on is registered in the item registers and moves into the response register
// once that register is free. An LED tick with the load on runs a serial
// multiply, a divide by 100, a slope divide and a serial multiply, one bit per
// cycle each, before it moves into the response register; a tick that stays
// below the turn-on voltage finishes after the first divide. A new request is
// taken once the previous tick has moved into the response register.
// Reset clears the configuration, the latch, the ranges and the enable level.
// A stalled response holds its register; a request may still be taken, and
// its result waits until the response register is free.
module electronic_load_enable_control_core
   import elc_pkg::*;
#(
   parameter int MEAS_WIDTH = ELC_MEAS_WIDTH,
   parameter int FRAC_BITS = ELC_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_mode,
   input  logic                  req_load_on,
   input  logic [MEAS_WIDTH-1:0] req_voltage,
   input  logic [MEAS_WIDTH-1:0] req_voltage_coarse,
   input  logic [MEAS_WIDTH-1:0] req_current,
   input  logic                  req_range_write,
   input  logic                  req_i_range_request,
   input  logic                  req_v_range_request,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_load_enable,
   output logic                  rsp_cv_select,
   output logic                  rsp_i_range_high,
   output logic                  rsp_v_range_high,
   output logic                  rsp_ramp_clear,
   output logic                  rsp_mode_changed,
   output logic                  rsp_track_voltage,
   output logic [MEAS_WIDTH-1:0] rsp_led_current_setpoint,
   output logic                  rsp_led_setpoint_valid,
   output logic [MEAS_WIDTH-1:0] rsp_short_current_setpoint,

   input  logic                  csr_write_en,
   input  elc_csr_index_type     csr_index,
   input  logic [MEAS_WIDTH-1:0] csr_write_data
);

   localparam int TW = MEAS_WIDTH + 4;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // Configuration registers.
   logic [MEAS_WIDTH-1:0]   von_ff, voff_ff, vo_ff, io_ff, imax_ff, vmax_ff;
   logic [ELC_RD_WIDTH-1:0] rd_ff;

   // Tick being worked on.
   elc_mode_type            mode_ff;
   logic                    on_ff, rw_ff, ireq_ff, vreq_ff;
   logic [MEAS_WIDTH-1:0]   volt_ff, coarse_ff, cur_ff;

   // Control state carried from tick to tick.
   logic                    von_latched_ff, von_latched_in;
   elc_mode_type            prev_mode_ff;
   logic                    i_range_ff, i_range_in;
   logic                    v_range_ff, v_range_in;
   logic                    enable_ff, enable_in;

   logic [1:0]              state_ff, state_in;
   logic                    accept, led_start, out_free, finish_fire;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_enable_ff, rsp_cv_ff, rsp_ramp_ff;
   logic                    rsp_changed_ff, rsp_track_ff, rsp_led_valid_ff;
   logic                    rsp_i_range_ff, rsp_v_range_ff;
   logic [MEAS_WIDTH-1:0]   rsp_led_sp_ff, rsp_short_sp_ff;

   logic                    ramp_in, changed_in, track_in, cv_in, led_valid_in;
   logic [MEAS_WIDTH-1:0]   led_sp_in, short_sp_in;

   elc_led_status_type      led_status;
   logic [MEAS_WIDTH-1:0]   led_setpoint;

   assign req_ready = state_ff == ST_IDLE;
   assign accept = req_valid && req_ready;
   assign led_start = accept && req_mode == MODE_LED && req_load_on;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish_fire = state_ff == ST_FINISH && out_free;

   elc_led_calc #(
      .MEAS_WIDTH(MEAS_WIDTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_led_calc (
      .clock(clock),
      .reset(reset),
      .start(led_start),
      .vo(vo_ff),
      .io(io_ff),
      .rd(rd_ff),
      .coarse(req_voltage_coarse),
      .status(led_status),
      .setpoint(led_setpoint)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = led_start ? ST_CALC : ST_FINISH;
            end
         end
         ST_CALC: begin
            if (led_status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Step of the control law for the tick held in the item registers.
   always_comb begin
      logic [TW-1:0] meas;
      logic [TW-1:0] thr_on;
      logic [TW-1:0] thr_off;

      i_range_in = rw_ff ? ireq_ff : i_range_ff;
      v_range_in = rw_ff ? vreq_ff : v_range_ff;
      enable_in = enable_ff;
      von_latched_in = von_latched_ff;
      changed_in = (mode_ff inside {[MODE_CC:MODE_SHORT]}) && mode_ff != prev_mode_ff;
      ramp_in = changed_in;
      track_in = 1'b0;
      cv_in = mode_ff == MODE_CV;
      led_valid_in = 1'b0;
      led_sp_in = '0;
      short_sp_in = '0;

      if (mode_ff == MODE_LED) begin
         v_range_in = 1'b1;
      end
      if (mode_ff == MODE_SHORT) begin
         short_sp_in = i_range_in ? MEAS_WIDTH'(ELC_SHORT_HIGH_CURRENT) :
                                    MEAS_WIDTH'(ELC_SHORT_LOW_CURRENT);
      end

      // In the low voltage range the fine reading is compared with ten times the levels.
      meas = v_range_in ? TW'(coarse_ff) : TW'(volt_ff);
      thr_on = v_range_in ? TW'(von_ff) : (TW'(von_ff) << 3) + (TW'(von_ff) << 1);
      thr_off = v_range_in ? TW'(voff_ff) : (TW'(voff_ff) << 3) + (TW'(voff_ff) << 1);

      if (!on_ff) begin
         enable_in = 1'b0;
         von_latched_in = 1'b0;
         ramp_in = 1'b1;
         track_in = 1'b1;
      end else if (mode_ff inside {[MODE_CC:MODE_CP]}) begin
         if (meas < thr_off) begin
            enable_in = 1'b0;
            ramp_in = 1'b1;
            track_in = 1'b1;
         end else begin
            enable_in = 1'b1;
         end
         if (!von_latched_ff) begin
            if (meas > thr_on) begin
               enable_in = 1'b1;
               von_latched_in = 1'b1;
            end else if (meas < thr_on) begin
               enable_in = 1'b0;
               ramp_in = 1'b1;
               track_in = 1'b1;
            end
         end
      end else if (mode_ff == MODE_LED) begin
         if (led_status.conducts) begin
            led_sp_in = led_setpoint;
            led_valid_in = 1'b1;
            enable_in = 1'b1;
         end else begin
            enable_in = 1'b0;
            ramp_in = 1'b1;
         end
      end else if (mode_ff == MODE_SHORT) begin
         enable_in = 1'b1;
      end

      if (!i_range_in && cur_ff > imax_ff) begin
         i_range_in = 1'b1;
      end
      if (!v_range_in && volt_ff > vmax_ff) begin
         v_range_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         von_latched_ff <= 1'b0;
         prev_mode_ff <= MODE_CC;
         i_range_ff <= 1'b0;
         v_range_ff <= 1'b0;
         enable_ff <= 1'b0;
         von_ff <= '0;
         voff_ff <= '0;
         vo_ff <= '0;
         io_ff <= '0;
         rd_ff <= '0;
         imax_ff <= '0;
         vmax_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish_fire) begin
            von_latched_ff <= von_latched_in;
            prev_mode_ff <= mode_ff;
            i_range_ff <= i_range_in;
            v_range_ff <= v_range_in;
            enable_ff <= enable_in;
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_VON_LEVEL: von_ff <= csr_write_data;
               CSR_VOFF_LEVEL: voff_ff <= csr_write_data;
               CSR_LED_FORWARD_VOLTAGE: vo_ff <= csr_write_data;
               CSR_LED_FORWARD_CURRENT: io_ff <= csr_write_data;
               CSR_LED_RD_PERCENT: rd_ff <= csr_write_data[ELC_RD_WIDTH-1:0];
               CSR_I_LOW_RANGE_MAX: imax_ff <= csr_write_data;
               CSR_V_LOW_RANGE_MAX: vmax_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         on_ff <= req_load_on;
         volt_ff <= req_voltage;
         coarse_ff <= req_voltage_coarse;
         cur_ff <= req_current;
         rw_ff <= req_range_write;
         ireq_ff <= req_i_range_request;
         vreq_ff <= req_v_range_request;
      end
      if (finish_fire) begin
         rsp_enable_ff <= enable_in;
         rsp_cv_ff <= cv_in;
         rsp_i_range_ff <= i_range_in;
         rsp_v_range_ff <= v_range_in;
         rsp_ramp_ff <= ramp_in;
         rsp_changed_ff <= changed_in;
         rsp_track_ff <= track_in;
         rsp_led_sp_ff <= led_sp_in;
         rsp_led_valid_ff <= led_valid_in;
         rsp_short_sp_ff <= short_sp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_load_enable = rsp_enable_ff;
   assign rsp_cv_select = rsp_cv_ff;
   assign rsp_i_range_high = rsp_i_range_ff;
   assign rsp_v_range_high = rsp_v_range_ff;
   assign rsp_ramp_clear = rsp_ramp_ff;
   assign rsp_mode_changed = rsp_changed_ff;
   assign rsp_track_voltage = rsp_track_ff;
   assign rsp_led_current_setpoint = rsp_led_sp_ff;
   assign rsp_led_setpoint_valid = rsp_led_valid_ff;
   assign rsp_short_current_setpoint = rsp_short_sp_ff;

`ifndef ASSERT_OFF
   a_led_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      led_status.done |-> state_ff == ST_CALC)
      else $error("LED set-point finished outside the calculation state");

   a_led_forces_v_range: assert property (@(posedge clock) disable iff (reset)
      finish_fire && mode_ff == MODE_LED |=> v_range_ff)
      else $error("LED tick left the voltage range low");

   a_change_clears_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_changed_ff |-> rsp_ramp_ff)
      else $error("Mode change without ramp clear");

   a_led_valid_enables: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_led_valid_ff |-> rsp_enable_ff && !rsp_cv_ff)
      else $error("LED set-point given with the load off or the CV loop selected");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import elc_pkg::*;

   localparam int MW = ELC_MEAS_WIDTH;
   localparam logic [MW-1:0] MEAS_MAX = '1;
   localparam elc_mode_type MODE_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_BLOCK_ITEMS = 238;
   localparam int DRAIN_CYCLES = 120;

   typedef bit [63:0] wide_t;

   typedef struct {
      elc_mode_type  mode;
      logic          load_on;
      logic [MW-1:0] voltage;
      logic [MW-1:0] coarse;
      logic [MW-1:0] current;
      logic          range_write;
      logic          i_req;
      logic          v_req;
   } load_tick_t;

   typedef struct packed {
      logic          load_enable;
      logic          cv_select;
      logic          i_range_high;
      logic          v_range_high;
      logic          ramp_clear;
      logic          mode_changed;
      logic          track_voltage;
      logic [MW-1:0] led_sp;
      logic          led_valid;
      logic [MW-1:0] short_sp;
   } load_response_t;

   typedef struct {
      logic [MW-1:0]           von_level;
      logic [MW-1:0]           voff_level;
      logic [MW-1:0]           led_vo;
      logic [MW-1:0]           led_io;
      logic [ELC_RD_WIDTH-1:0] led_rd;
      logic [MW-1:0]           i_max;
      logic [MW-1:0]           v_max;
   } load_settings_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_mode = MODE_CC;
   logic              req_load_on = 1'b0;
   logic [MW-1:0]     req_voltage = '0;
   logic [MW-1:0]     req_voltage_coarse = '0;
   logic [MW-1:0]     req_current = '0;
   logic              req_range_write = 1'b0;
   logic              req_i_range_request = 1'b0;
   logic              req_v_range_request = 1'b0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_load_enable;
   logic              rsp_cv_select;
   logic              rsp_i_range_high;
   logic              rsp_v_range_high;
   logic              rsp_ramp_clear;
   logic              rsp_mode_changed;
   logic              rsp_track_voltage;
   logic [MW-1:0]     rsp_led_current_setpoint;
   logic              rsp_led_setpoint_valid;
   logic [MW-1:0]     rsp_short_current_setpoint;

   logic              csr_write_en = 1'b0;
   elc_csr_index_type csr_index = CSR_VON_LEVEL;
   logic [MW-1:0]     csr_write_data = '0;

   // Mirror of the block's registers and state.
   load_settings_t settings = '{default: '0};
   logic         von_latched_q = 1'b0;
   elc_mode_type prev_mode_q = MODE_CC;
   logic         i_range_q = 1'b0;
   logic         v_range_q = 1'b0;
   logic         enable_q = 1'b0;

   load_response_t awaited_responses[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;

   electronic_load_enable_control_core dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_ready                  (req_ready),
      .req_mode                   (req_mode),
      .req_load_on                (req_load_on),
      .req_voltage                (req_voltage),
      .req_voltage_coarse         (req_voltage_coarse),
      .req_current                (req_current),
      .req_range_write            (req_range_write),
      .req_i_range_request        (req_i_range_request),
      .req_v_range_request        (req_v_range_request),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_load_enable            (rsp_load_enable),
      .rsp_cv_select              (rsp_cv_select),
      .rsp_i_range_high           (rsp_i_range_high),
      .rsp_v_range_high           (rsp_v_range_high),
      .rsp_ramp_clear             (rsp_ramp_clear),
      .rsp_mode_changed           (rsp_mode_changed),
      .rsp_track_voltage          (rsp_track_voltage),
      .rsp_led_current_setpoint   (rsp_led_current_setpoint),
      .rsp_led_setpoint_valid     (rsp_led_setpoint_valid),
      .rsp_short_current_setpoint (rsp_short_current_setpoint),
      .csr_write_en               (csr_write_en),
      .csr_index                  (csr_index),
      .csr_write_data             (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Voltage at which an LED starts to conduct: Vo less the Rd share of Vo.
   function automatic wide_t led_turn_on_voltage();
      wide_t vo;
      wide_t drop;
      vo = settings.led_vo;
      drop = (vo * ELC_RD_SCALE * wide_t'(settings.led_rd)) / (ELC_RD_SCALE * ELC_RD_SCALE);
      return (drop > vo) ? 0 : vo - drop;
   endfunction

   function automatic logic [MW-1:0] led_setpoint(input wide_t turn_on, input wide_t coarse);
      wide_t vo;
      wide_t io_q;
      wide_t den;
      wide_t k;
      wide_t d;
      wide_t e;
      wide_t val;
      vo = settings.led_vo;
      io_q = wide_t'(settings.led_io) << ELC_FRAC_BITS;
      den = vo - turn_on;
      if (den == 0)
         return settings.led_io;
      k = io_q / den;
      if (coarse >= vo) begin
         d = coarse - vo;
         if (k != 0 && d > (64'h7FFF_FFFF_FFFF_FFFF / k))
            return MEAS_MAX;
         val = d * k + io_q;
      end else begin
         e = (vo - coarse) * k;
         val = (e > io_q) ? 0 : io_q - e;
      end
      val = val >> ELC_FRAC_BITS;
      return (val > MEAS_MAX) ? MEAS_MAX : val[MW-1:0];
   endfunction

   // Advances the mirrored state by one tick and returns that tick's response.
   function automatic load_response_t evaluate_tick(input load_tick_t t);
      load_response_t r;
      wide_t meas;
      wide_t thr_on;
      wide_t thr_off;
      wide_t turn_on;
      r = '0;
      if (t.range_write) begin
         i_range_q = t.i_req;
         v_range_q = t.v_req;
      end
      if (t.mode <= MODE_SHORT && t.mode != prev_mode_q) begin
         r.mode_changed = 1'b1;
         r.ramp_clear = 1'b1;
      end
      r.cv_select = (t.mode == MODE_CV);
      if (t.mode == MODE_LED)
         v_range_q = 1'b1;
      if (t.mode == MODE_SHORT)
         r.short_sp = i_range_q ? MW'(ELC_SHORT_HIGH_CURRENT) : MW'(ELC_SHORT_LOW_CURRENT);
      prev_mode_q = t.mode;

      if (!t.load_on) begin
         enable_q = 1'b0;
         von_latched_q = 1'b0;
         r.ramp_clear = 1'b1;
         r.track_voltage = 1'b1;
      end else if (t.mode <= MODE_CP) begin
         meas = v_range_q ? wide_t'(t.coarse) : wide_t'(t.voltage);
         thr_off = v_range_q ? wide_t'(settings.voff_level) : wide_t'(settings.voff_level) * 10;
         thr_on = v_range_q ? wide_t'(settings.von_level) : wide_t'(settings.von_level) * 10;
         if (meas < thr_off) begin
            enable_q = 1'b0;
            r.ramp_clear = 1'b1;
            r.track_voltage = 1'b1;
         end else begin
            enable_q = 1'b1;
         end
         if (!von_latched_q) begin
            if (meas > thr_on) begin
               enable_q = 1'b1;
               von_latched_q = 1'b1;
            end else if (meas < thr_on) begin
               enable_q = 1'b0;
               r.ramp_clear = 1'b1;
               r.track_voltage = 1'b1;
            end
         end
      end else if (t.mode == MODE_LED) begin
         turn_on = led_turn_on_voltage();
         if (wide_t'(t.coarse) >= turn_on) begin
            r.led_sp = led_setpoint(turn_on, t.coarse);
            r.led_valid = 1'b1;
            enable_q = 1'b1;
         end else begin
            enable_q = 1'b0;
            r.ramp_clear = 1'b1;
         end
      end else if (t.mode == MODE_SHORT) begin
         enable_q = 1'b1;
      end

      if (!i_range_q && t.current > settings.i_max)
         i_range_q = 1'b1;
      if (!v_range_q && t.voltage > settings.v_max)
         v_range_q = 1'b1;

      r.load_enable = enable_q;
      r.i_range_high = i_range_q;
      r.v_range_high = v_range_q;
      return r;
   endfunction

   function automatic load_tick_t make_tick(input elc_mode_type mode, input logic on,
                                            input wide_t voltage, input wide_t coarse,
                                            input wide_t current, input logic rw,
                                            input logic ir, input logic vr);
      load_tick_t t;
      t.mode = mode;
      t.load_on = on;
      t.voltage = voltage[MW-1:0];
      t.coarse = coarse[MW-1:0];
      t.current = current[MW-1:0];
      t.range_write = rw;
      t.i_req = ir;
      t.v_req = vr;
      return t;
   endfunction

   // Values close to a threshold half the time, full-range or extreme values otherwise.
   function automatic logic [MW-1:0] near_value(input wide_t centre);
      wide_t v;
      case ($urandom_range(0, 3))
         0: return MW'($urandom_range(0, MEAS_MAX));
         1: return $urandom_range(0, 1) ? MEAS_MAX : '0;
         default: begin
            v = centre + $urandom_range(0, 8);
            if (v < 4)
               return '0;
            v = v - 4;
            return (v > MEAS_MAX) ? MEAS_MAX : v[MW-1:0];
         end
      endcase
   endfunction

   function automatic load_tick_t random_tick();
      load_tick_t t;
      wide_t pick;
      case ($urandom_range(0, 9))
         0: t.mode = MODE_CC;
         1: t.mode = MODE_CV;
         2: t.mode = MODE_CR;
         3: t.mode = MODE_CP;
         4, 5: t.mode = MODE_LED;
         6: t.mode = MODE_SHORT;
         7: t.mode = MODE_DYNAMIC;
         8: t.mode = MODE_UNUSED;
         default: t.mode = elc_mode_type'($urandom_range(0, 7));
      endcase
      t.load_on = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 2))
         0: pick = wide_t'(settings.von_level) * 10;
         1: pick = wide_t'(settings.voff_level) * 10;
         default: pick = settings.v_max;
      endcase
      t.voltage = near_value(pick);
      case ($urandom_range(0, 3))
         0: pick = settings.von_level;
         1: pick = settings.voff_level;
         2: pick = settings.led_vo;
         default: pick = led_turn_on_voltage();
      endcase
      t.coarse = near_value(pick);
      t.current = near_value(settings.i_max);
      t.range_write = ($urandom_range(0, 5) == 0);
      t.i_req = $urandom_range(0, 1);
      t.v_req = $urandom_range(0, 1);
      return t;
   endfunction

   function automatic load_settings_t random_settings();
      load_settings_t s;
      s.von_level = ($urandom_range(0, 3) == 0) ? MW'($urandom_range(0, MEAS_MAX))
                                                : MW'($urandom_range(0, 26000));
      s.voff_level = ($urandom_range(0, 3) == 0) ? MW'($urandom_range(0, MEAS_MAX))
                                                 : MW'($urandom_range(0, s.von_level));
      s.led_vo = ($urandom_range(0, 1) == 0) ? MW'($urandom_range(0, MEAS_MAX))
                                             : MW'($urandom_range(0, 2000));
      s.led_io = MW'($urandom_range(0, MEAS_MAX));
      s.led_rd = ($urandom_range(0, 4) == 0) ? ELC_RD_WIDTH'($urandom_range(0, 127))
                                             : ELC_RD_WIDTH'($urandom_range(0, 100));
      s.i_max = MW'($urandom_range(0, MEAS_MAX));
      s.v_max = MW'($urandom_range(0, MEAS_MAX));
      return s;
   endfunction

   task automatic write_register(input elc_csr_index_type idx, input logic [MW-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // Called only while the block is idle.
   task automatic apply_settings(input load_settings_t s);
      settings = s;
      write_register(CSR_VON_LEVEL, s.von_level);
      write_register(CSR_VOFF_LEVEL, s.voff_level);
      write_register(CSR_LED_FORWARD_VOLTAGE, s.led_vo);
      write_register(CSR_LED_FORWARD_CURRENT, s.led_io);
      write_register(CSR_LED_RD_PERCENT, MW'(s.led_rd));
      write_register(CSR_I_LOW_RANGE_MAX, s.i_max);
      write_register(CSR_V_LOW_RANGE_MAX, s.v_max);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct <= recv_pct;
   endtask

   // Valid is left high after a transfer; the next call either keeps it high
   // or lowers it for an idle gap.
   task automatic send_tick(input load_tick_t t);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= t.mode;
      req_load_on <= t.load_on;
      req_voltage <= t.voltage;
      req_voltage_coarse <= t.coarse;
      req_current <= t.current;
      req_range_write <= t.range_write;
      req_i_range_request <= t.i_req;
      req_v_range_request <= t.v_req;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      awaited_responses.push_back(evaluate_tick(t));
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver: random stalls, or a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      load_response_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: response transfer with no tick outstanding", $time);
            mismatch_count++;
         end else begin
            want = awaited_responses.pop_front();
            compare_field("load_enable", want.load_enable, rsp_load_enable);
            compare_field("cv_select", want.cv_select, rsp_cv_select);
            compare_field("i_range_high", want.i_range_high, rsp_i_range_high);
            compare_field("v_range_high", want.v_range_high, rsp_v_range_high);
            compare_field("ramp_clear", want.ramp_clear, rsp_ramp_clear);
            compare_field("mode_changed", want.mode_changed, rsp_mode_changed);
            compare_field("track_voltage", want.track_voltage, rsp_track_voltage);
            compare_field("led_current_setpoint", want.led_sp, rsp_led_current_setpoint);
            compare_field("led_setpoint_valid", want.led_valid, rsp_led_setpoint_valid);
            compare_field("short_current_setpoint", want.short_sp,
                          rsp_short_current_setpoint);
         end
      end
   end

   function automatic load_settings_t bench_settings();
      load_settings_t s;
      s.von_level = 100;
      s.voff_level = 60;
      s.led_vo = 50000;
      s.led_io = 20000;
      s.led_rd = 10;
      s.i_max = 150000;
      s.v_max = 200000;
      return s;
   endfunction

   task automatic test_thresholds();
      apply_settings(bench_settings());
      // Low range compares the fine voltage with ten times each threshold.
      send_tick(make_tick(MODE_CC, 1, 999, 0, 0, 0, 0, 0));
      send_tick(make_tick(MODE_CC, 1, 1000, 0, 0, 0, 0, 0));
      send_tick(make_tick(MODE_CC, 1, 1001, 0, 0, 0, 0, 0));
      send_tick(make_tick(MODE_CV, 1, 700, 0, 0, 0, 0, 0));
      send_tick(make_tick(MODE_CR, 1, 599, 0, 0, 0, 0, 0));
      send_tick(make_tick(MODE_CP, 0, 5000, 0, 0, 0, 0, 0));
      // High range compares the coarse voltage with the thresholds as written.
      send_tick(make_tick(MODE_CC, 1, 0, 100, 0, 1, 0, 1));
      send_tick(make_tick(MODE_CC, 1, 0, 59, 0, 0, 0, 0));
      wait_for_idle();
   endtask

   task automatic test_modes();
      send_tick(make_tick(MODE_DYNAMIC, 1, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(MODE_UNUSED, 1, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(MODE_SHORT, 1, 0, 0, 0, 1, 0, 0));
      send_tick(make_tick(MODE_SHORT, 1, 0, 0, 0, 1, 1, 0));
      send_tick(make_tick(MODE_UNUSED, 1, MEAS_MAX, MEAS_MAX, MEAS_MAX, 1, 1, 1));
      send_tick(make_tick(MODE_CC, 0, 0, 0, 0, 1, 0, 0));
      wait_for_idle();
   endtask

   task automatic test_led_law();
      load_settings_t s;
      s = bench_settings();
      apply_settings(s);
      send_tick(make_tick(MODE_LED, 1, 0, 44999, 0, 0, 0, 0));
      send_tick(make_tick(MODE_LED, 1, 0, 45000, 0, 0, 0, 0));
      send_tick(make_tick(MODE_LED, 1, 0, 49000, 0, 0, 0, 0));
      send_tick(make_tick(MODE_LED, 1, 0, 50000, 0, 0, 0, 0));
      send_tick(make_tick(MODE_LED, 1, 0, MEAS_MAX, 0, 0, 0, 0));
      send_tick(make_tick(MODE_LED, 0, 0, 50000, 0, 0, 0, 0));
      wait_for_idle();
      // No dynamic resistance leaves a zero slope divisor: the set-point is Io.
      s.led_rd = 0;
      apply_settings(s);
      send_tick(make_tick(MODE_LED, 1, 0, 50000, 0, 0, 0, 0));
      wait_for_idle();
      // A drop larger than Vo puts the turn-on voltage at zero.
      s.led_rd = 127;
      apply_settings(s);
      send_tick(make_tick(MODE_LED, 1, 0, 0, 0, 0, 0, 0));
      wait_for_idle();
   endtask

   task automatic test_range_switching();
      apply_settings(bench_settings());
      send_tick(make_tick(MODE_CC, 1, 200001, 0, 150001, 1, 0, 0));
      send_tick(make_tick(MODE_CC, 1, 200000, 0, 150000, 1, 0, 0));
      wait_for_idle();
   endtask

   task automatic test_random_phases();
      load_settings_t s;
      for (int block = 0; block < 8; block++) begin
         if (block == 0) begin
            s = '{default: '0};
         end else if (block == 1) begin
            s = '{default: MEAS_MAX};
            s.led_rd = 100;
         end else begin
            s = random_settings();
         end
         apply_settings(s);
         case (block % 4)
            0: set_idling(0, 0);
            1: set_idling(52, 0);
            2: set_idling(0, 52);
            default: set_idling(35, 35);
         endcase
         for (int n = 0; n < RANDOM_BLOCK_ITEMS; n++)
            send_tick(random_tick());
         wait_for_idle();
      end
   endtask

   // The receiver holds off while the sender keeps offering ticks, so the
   // block fills up and stops taking requests.
   task automatic test_backpressure();
      apply_settings(random_settings());
      set_idling(0, 0);
      hold_left <= 400;
      for (int n = 0; n < 16; n++)
         send_tick(random_tick());
      wait_for_idle();
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_thresholds();
      test_modes();
      test_led_law();
      test_range_switching();
      test_random_phases();
      test_backpressure();
      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
